// ===== design/ofbf_pkg.sv =====
// Shared types and codes for the overwrite-oldest byte FIFO.
package ofbf_pkg;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
      logic       rx_error;
      logic [6:0] read_count;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       status;
      logic       last;
      logic [7:0] fill_after;
   } rsp_type;

endpackage

// ===== design/ofbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ofbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/overwrite_oldest_byte_fifo.sv =====
// Byte receive FIFO over a circular RAM that overwrites the oldest byte when full.
//
// A push is taken and gives no result; busy stays low, so pushes may arrive back to
// back. A read of n bytes (n = min(count, fill), count clamped to MAX_BURST) holds busy
// through S_FETCH, which fetches the first byte from the registered RAM read port, and
// S_EMIT, which then gives one registered byte per cycle, the last one marked. A read
// with nothing to give returns one empty-status item in the cycle after the accept and
// does not raise busy. Results are shown for exactly one cycle with rsp_strobe and cannot
// be held off by the receiver.
module overwrite_oldest_byte_fifo #(
   parameter int DEPTH     = 128,
   parameter int MAX_BURST = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ofbf_pkg::req_type req_item,
   output logic             rsp_strobe,
   output ofbf_pkg::rsp_type rsp_item
);

   import ofbf_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = $clog2(MAX_BURST + 1);
   localparam int NW = (FW > 7) ? FW : 7;
   localparam logic [PW-1:0] LastPtr  = PW'(DEPTH - 1);
   localparam logic [FW-1:0] FullFill = FW'(DEPTH);
   localparam logic [6:0]    MaxCount = 7'(MAX_BURST);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_FETCH = 3'b010,
      S_EMIT  = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic          accept;
   logic          ram_wr_en;
   logic [PW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;
   logic [PW-1:0] wr_ptr_next, rd_ptr_next;
   logic [6:0]    count_clamped;
   logic [NW-1:0] burst_len;
   logic [FW-1:0] fill_dec;

   assign accept      = start && !busy;
   assign wr_ptr_next = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
   assign fill_dec    = fill_ff - 1'b1;
   assign count_clamped = (req_item.read_count > MaxCount) ? MaxCount : req_item.read_count;
   assign burst_len   = (NW'(count_clamped) < NW'(fill_ff)) ? NW'(count_clamped)
                                                             : NW'(fill_ff);
   assign ram_wr_en   = accept && (req_item.command == CMD_PUSH) && !req_item.rx_error;
   assign ram_rd_addr = (state_ff == S_EMIT) ? rd_ptr_next : rd_ptr_ff;

   ofbf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_item.rx_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      fill_in       = fill_ff;
      remain_in     = remain_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_item.command == CMD_PUSH) begin
                  if (!req_item.rx_error) begin
                     wr_ptr_in = wr_ptr_next;
                     if (fill_ff == FullFill) begin
                        rd_ptr_in = rd_ptr_next;
                     end else begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end
               end else if (burst_len == '0) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.data_byte  = '0;
                  rsp_in.status     = STATUS_EMPTY;
                  rsp_in.last       = 1'b1;
                  rsp_in.fill_after = 8'(fill_ff);
               end else begin
                  remain_in = CW'(burst_len);
                  state_in  = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.data_byte  = ram_rd_data;
            rsp_in.status     = STATUS_OK;
            rsp_in.last       = (remain_ff == CW'(1));
            rsp_in.fill_after = 8'(fill_dec);
            fill_in           = fill_dec;
            rd_ptr_in         = rd_ptr_next;
            remain_in         = remain_ff - 1'b1;
            if (remain_ff == CW'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
         remain_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fill_ff       <= fill_in;
         remain_ff     <= remain_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== design/ofbf_checker.sv =====
// Port-level checks for the overwrite-oldest byte FIFO, bound to the top level.
module ofbf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input ofbf_pkg::req_type req_item,
   input logic              rsp_strobe,
   input ofbf_pkg::rsp_type rsp_item
);

   import ofbf_pkg::*;

   // empty item is always a zeroed, final item
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.status == STATUS_EMPTY)
      |-> rsp_item.last && (rsp_item.data_byte == 8'd0))
      else $error("empty item not last or not zero");

   // busy only follows an accepted read
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && ($past(req_item.command) == CMD_READ))
      else $error("busy raised without a read");

   // a burst continues without gaps and the fill drops by one per item
   a_burst_next: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last
      |=> rsp_strobe && (rsp_item.status == STATUS_OK)
          && (rsp_item.fill_after == $past(rsp_item.fill_after) - 8'd1))
      else $error("burst gap or fill mismatch");

   // an unfinished burst keeps the block busy
   a_burst_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("idle in the middle of a burst");

endmodule

bind overwrite_oldest_byte_fifo ofbf_checker u_ofbf_checker (.*);

// ===== test/overwrite_oldest_byte_fifo_test.sv =====
// Testbench for the overwrite-oldest byte FIFO: directed, wrap, overwrite and random item tests.
module overwrite_oldest_byte_fifo_test;
   import ofbf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH  = 128;
   localparam int BURST_LIMIT = 64;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // shadow copy of the ring and what it is due to deliver
   logic [7:0] ring_bytes [RING_DEPTH];
   logic [6:0] ring_wr   = '0;
   logic [6:0] ring_rd   = '0;
   int         ring_fill = 0;
   rsp_type    due_bytes [$];
   int         failures  = 0;
   bit         gaps_on   = 1'b1;

   overwrite_oldest_byte_fifo #(
      .DEPTH    (RING_DEPTH),
      .MAX_BURST(BURST_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("overwrite_oldest_byte_fifo verification failed");
      $finish;
   end

   task automatic apply_to_ring(input req_type r);
      int      n;
      rsp_type res;
      if (r.command == CMD_PUSH) begin
         if (r.rx_error == 1'b0) begin
            ring_bytes[ring_wr] = r.rx_byte;
            ring_wr = ring_wr + 7'd1;
            if (ring_fill == RING_DEPTH) begin
               ring_rd = ring_rd + 7'd1;
            end else begin
               ring_fill++;
            end
         end
      end else begin
         n = (r.read_count > BURST_LIMIT) ? BURST_LIMIT : int'(r.read_count);
         if (n > ring_fill) n = ring_fill;
         if (n == 0) begin
            res.data_byte  = 8'h00;
            res.status     = STATUS_EMPTY;
            res.last       = 1'b1;
            res.fill_after = ring_fill[7:0];
            due_bytes.push_back(res);
         end else begin
            for (int k = 0; k < n; k++) begin
               res.data_byte  = ring_bytes[ring_rd];
               ring_rd        = ring_rd + 7'd1;
               ring_fill--;
               res.status     = STATUS_OK;
               res.last       = (k == n - 1);
               res.fill_after = ring_fill[7:0];
               due_bytes.push_back(res);
            end
         end
      end
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (!gaps_on || roll < 50) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic req_type push_req(logic [7:0] b, logic err, logic [6:0] cnt);
      req_type r;
      r.command    = CMD_PUSH;
      r.rx_byte    = b;
      r.rx_error   = err;
      r.read_count = cnt;
      return r;
   endfunction

   function automatic req_type read_req(logic [6:0] cnt, logic [7:0] b, logic err);
      req_type r;
      r.command    = CMD_READ;
      r.rx_byte    = b;
      r.rx_error   = err;
      r.read_count = cnt;
      return r;
   endfunction

   task automatic send_item(input req_type r);
      int gap;
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      apply_to_ring(r);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_strobe) begin
         if (due_bytes.size() == 0) begin
            $error("unexpected item: data_byte 0x%02h status %0d", rsp_item.data_byte,
                   rsp_item.status);
            failures++;
         end else begin
            exp = due_bytes.pop_front();
            if (rsp_item.data_byte !== exp.data_byte) begin
               $error("data_byte: expected 0x%02h, got 0x%02h", exp.data_byte,
                      rsp_item.data_byte);
               failures++;
            end
            if (rsp_item.status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, rsp_item.status);
               failures++;
            end
            if (rsp_item.last !== exp.last) begin
               $error("last: expected %0d, got %0d", exp.last, rsp_item.last);
               failures++;
            end
            if (rsp_item.fill_after !== exp.fill_after) begin
               $error("fill_after: expected %0d, got %0d", exp.fill_after,
                      rsp_item.fill_after);
               failures++;
            end
         end
      end
   end

   // empty reads, ignored fields, dropped bytes, clamping, count above fill
   task automatic test_directed();
      send_item(read_req(7'd0, 8'h00, 1'b0));
      send_item(read_req(7'd127, 8'hFF, 1'b1));
      send_item(push_req(8'h33, 1'b1, 7'd0));
      send_item(read_req(7'd5, 8'h00, 1'b0));
      send_item(push_req(8'h00, 1'b0, 7'h7F));
      send_item(push_req(8'hFF, 1'b0, 7'h00));
      send_item(push_req(8'h5A, 1'b1, 7'h7F));
      send_item(read_req(7'd0, 8'hFF, 1'b1));
      send_item(read_req(7'd1, 8'h00, 1'b0));
      send_item(push_req(8'hA5, 1'b0, 7'h2A));
      send_item(push_req(8'h5A, 1'b0, 7'h55));
      send_item(read_req(7'd64, 8'hFF, 1'b1));
      send_item(read_req(7'd2, 8'h00, 1'b0));
      for (int i = 0; i < 6; i++) send_item(push_req(8'h01 << i, 1'b0, 7'd0));
      send_item(read_req(7'd65, 8'h00, 1'b0));
      send_item(push_req(8'h80, 1'b0, 7'd0));
      send_item(read_req(7'd3, 8'h00, 1'b0));
   endtask

   // fill exactly to depth, then bursts sized so one ends exactly at the top of the store
   task automatic test_fill_and_wrap();
      gaps_on = 1'b0;
      while (ring_fill < RING_DEPTH)
         send_item(push_req(8'($urandom), 1'b0, 7'($urandom)));
      gaps_on = 1'b1;
      send_item(read_req(7'd100, 8'($urandom), 1'($urandom)));
      while (ring_rd != 7'd0 && ring_fill > 0) begin
         send_item(read_req((ring_rd > 7'd64) ? 7'(RING_DEPTH - int'(ring_rd)) : 7'd64,
                            8'($urandom), 1'($urandom)));
      end
      send_item(read_req(7'd1, 8'($urandom), 1'($urandom)));
   endtask

   // push past full so the oldest bytes get overwritten, then drain
   task automatic test_overwrite();
      int good;
      good = 0;
      while (good < RING_DEPTH + 7) begin
         if ($urandom_range(7) == 0) begin
            send_item(push_req(8'($urandom), 1'b1, 7'($urandom)));
         end else begin
            send_item(push_req(8'($urandom), 1'b0, 7'($urandom)));
            good++;
         end
      end
      send_item(read_req(7'd64, 8'($urandom), 1'($urandom)));
      send_item(read_req(7'd127, 8'($urandom), 1'($urandom)));
      send_item(read_req(7'd3, 8'($urandom), 1'($urandom)));
   endtask

   task automatic test_random();
      int         roll;
      logic [6:0] cnt;
      for (int i = 0; i < 120; i++) begin
         roll = $urandom_range(99);
         if (roll < 65) begin
            send_item(push_req(8'($urandom), 1'($urandom_range(9) == 0), 7'($urandom)));
         end else begin
            roll = $urandom_range(99);
            if (roll < 15) cnt = 7'd0;
            else if (roll < 75) cnt = 7'($urandom_range(16, 1));
            else cnt = 7'($urandom_range(127, 17));
            send_item(read_req(cnt, 8'($urandom), 1'($urandom)));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_wrap();
      test_overwrite();
      test_random();
      start <= 1'b0;
      for (int w = 0; w < 2000 && due_bytes.size() > 0; w++) @(posedge clock);
      if (due_bytes.size() > 0) begin
         $error("%0d items never arrived", due_bytes.size());
         failures++;
      end
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("overwrite_oldest_byte_fifo verification clean");
      end else begin
         $display("overwrite_oldest_byte_fifo verification failed");
      end
      $finish;
   end

endmodule
